### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define MTA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Clocked check that also holds across reset.
`define MTA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

### rtl/mta_pkg.sv
package mta_pkg;

  localparam int CHANNEL_W = 4;
  localparam int ANGLE_W   = 37;
  localparam int TURNS_W   = 16;

  typedef logic [CHANNEL_W-1:0]      channel_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [TURNS_W-1:0] turns_t;

  localparam channel_t FIRST_MULTI_CHANNEL = 4'd9;
  localparam channel_t HALF_SCALE_CHANNEL  = 4'd13;

  // One full turn in units of 1/5120 degree.
  localparam angle_t UNITS_PER_TURN = 37'sd1843200;

  // Units per converter count at the reference width of 12 bits.
  localparam int REF_SAMPLE_BITS  = 12;
  localparam int COUNT_UNITS      = 450;
  // The half-scale channel weighs each count with 256 units.
  localparam int HALF_SCALE_SHIFT = 8;

  localparam turns_t TURNS_MAX = 16'sh7FFF;
  localparam turns_t TURNS_MIN = 16'sh8000;

  localparam int DEFAULT_MULTI_TURN_CHANNELS = 4;
  localparam int DEFAULT_SAMPLE_BITS         = 12;

endpackage

### rtl/multi_turn_angle_tracker.sv
// Multi-turn angle tracker.
// The sample channel carries one converter reading per transfer, with its channel number
// and the channel's calibration zero. The result channel returns the echoed channel, the
// angle in signed units of 1/5120 degree, and the turn count of multi-turn channels.
// Both channels use valid/stall: a transfer happens on a rising edge with valid high and
// stall low.
// A sample passes the middle stage and then the result register, and one sample can be
// taken in every cycle while the receiver does not stall.
// The rate is set by the per-channel read-modify-write of the tracking memory: the entry
// is read when the sample is taken and written back one stage later, and a back-to-back
// sample of the same channel picks up the new entry through a forwarding register.
// Reset clears the pipeline valid bits and the per-channel seeded flags. The memory needs
// no clearing pass, since an unseeded channel never uses its entry, so samples are taken
// from the first cycle after reset.
// When the receiver stalls, the result register holds its contents. One more sample can
// still enter the middle stage, after which sample_stall rises until the result moves on.
module multi_turn_angle_tracker #(
  parameter int MULTI_TURN_CHANNELS = mta_pkg::DEFAULT_MULTI_TURN_CHANNELS,
  parameter int SAMPLE_BITS         = mta_pkg::DEFAULT_SAMPLE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  mta_pkg::channel_t      channel,
  input  logic [SAMPLE_BITS-1:0] raw_sample,
  input  logic [SAMPLE_BITS-1:0] zero_offset,
  output logic                   result_valid,
  input  logic                   result_stall,
  output mta_pkg::channel_t      channel_out,
  output mta_pkg::angle_t        angle,
  output mta_pkg::turns_t        turns
);
  import mta_pkg::*;

  localparam int IDX_W    = (MULTI_TURN_CHANNELS > 1) ? $clog2(MULTI_TURN_CHANNELS) : 1;
  localparam int DIFF_W   = SAMPLE_BITS + 1;
  localparam int SHIFT_UP = (SAMPLE_BITS <= REF_SAMPLE_BITS) ? REF_SAMPLE_BITS - SAMPLE_BITS : 0;
  localparam int SHIFT_DN = (SAMPLE_BITS > REF_SAMPLE_BITS) ? SAMPLE_BITS - REF_SAMPLE_BITS : 0;
  localparam int SCALE    = COUNT_UNITS << SHIFT_UP;
  localparam int SCALE_W  = $clog2(SCALE + 1) + 1;
  localparam int PROD_W   = DIFF_W + SCALE_W;
  localparam int ENTRY_W  = SAMPLE_BITS + TURNS_W;

  localparam logic [CHANNEL_W:0]      MT_LIMIT   = (CHANNEL_W + 1)'(MULTI_TURN_CHANNELS);
  localparam logic signed [SCALE_W-1:0] SCALE_S  = SCALE_W'(SCALE);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'd1 << SHIFT_DN) - 64'd1);
  localparam logic signed [DIFF_W-1:0] HALF_RANGE = DIFF_W'(64'd1 << (SAMPLE_BITS - 1));
  localparam logic signed [DIFF_W-1:0] NEG_HALF   = -HALF_RANGE;

  // Input side decode.
  logic                     in_accept;
  channel_t                 in_rel;
  logic                     in_multi;
  logic                     in_half;
  logic [IDX_W-1:0]         in_idx;
  logic signed [DIFF_W-1:0] in_diff;
  logic signed [PROD_W-1:0] in_scaled;
  logic signed [PROD_W-1:0] in_rounded;
  logic signed [PROD_W-1:0] in_part;

  // Middle stage: the item whose memory entry is being read back.
  logic                     s1_valid;
  logic                     s1_adv;
  channel_t                 s1_channel;
  logic [SAMPLE_BITS-1:0]   s1_sample;
  logic                     s1_multi;
  logic [IDX_W-1:0]         s1_idx;
  logic signed [PROD_W-1:0] s1_part;
  logic                     s1_fwd;
  logic [SAMPLE_BITS-1:0]   fwd_prev;
  turns_t                   fwd_turns;

  // Tracking memory: previous sample and turn count of each multi-turn channel.
  logic [ENTRY_W-1:0]       track_mem [MULTI_TURN_CHANNELS];
  logic [ENTRY_W-1:0]       rd_entry;
  logic [MULTI_TURN_CHANNELS-1:0] seeded;
  logic                     wr_en;

  logic                     was_seeded;
  logic [SAMPLE_BITS-1:0]   prev_eff;
  turns_t                   turns_old;
  turns_t                   turns_new;
  turns_t                   turns_res;
  logic signed [DIFF_W-1:0] jump;
  angle_t                   angle_next;

  assign in_accept    = sample_valid && !sample_stall;
  assign s1_adv       = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !s1_adv;
  assign wr_en        = s1_adv && s1_multi;

  // Channel decode and the single-turn part, both known from the sample alone.
  always_comb begin
    in_rel   = channel - FIRST_MULTI_CHANNEL;
    in_multi = (channel >= FIRST_MULTI_CHANNEL) && ({1'b0, in_rel} < MT_LIMIT);
    in_half  = (channel == HALF_SCALE_CHANNEL) && !in_multi;
    in_idx   = in_rel[IDX_W-1:0];
    in_diff  = signed'({1'b0, raw_sample}) - signed'({1'b0, zero_offset});
    // Widths above the reference width divide by a power of two, truncating toward zero.
    in_scaled  = PROD_W'(in_diff) * PROD_W'(SCALE_S);
    in_rounded = in_scaled + (in_scaled[PROD_W-1] ? ROUND_BIAS : '0);
    if (in_half) begin
      in_part = PROD_W'(in_diff) <<< HALF_SCALE_SHIFT;
    end else begin
      in_part = in_rounded >>> SHIFT_DN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // A sample of the channel that is being written back in the same cycle takes the
  // new entry from the forwarding register instead of the memory.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_channel <= channel;
      s1_sample  <= raw_sample;
      s1_multi   <= in_multi;
      s1_idx     <= in_idx;
      s1_part    <= in_part;
      s1_fwd     <= wr_en && in_multi && (s1_idx == in_idx);
      fwd_prev   <= s1_sample;
      fwd_turns  <= turns_new;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_multi) begin
      rd_entry <= track_mem[in_idx];
    end
    if (wr_en) begin
      track_mem[s1_idx] <= {s1_sample, turns_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded <= '0;
    end else if (wr_en) begin
      seeded[s1_idx] <= 1'b1;
    end
  end

  // Unwrap: a large negative jump means the sensor passed zero going up.
  always_comb begin
    was_seeded = seeded[s1_idx];
    if (was_seeded) begin
      prev_eff  = s1_fwd ? fwd_prev : rd_entry[ENTRY_W-1:TURNS_W];
      turns_old = s1_fwd ? fwd_turns : turns_t'(rd_entry[TURNS_W-1:0]);
    end else begin
      prev_eff  = s1_sample;
      turns_old = '0;
    end
    jump      = signed'({1'b0, s1_sample}) - signed'({1'b0, prev_eff});
    turns_new = turns_old;
    if (jump < NEG_HALF) begin
      if (turns_old != TURNS_MAX) begin
        turns_new = turns_old + 16'sd1;
      end
    end else if (jump > HALF_RANGE) begin
      if (turns_old != TURNS_MIN) begin
        turns_new = turns_old - 16'sd1;
      end
    end
    turns_res  = s1_multi ? turns_new : '0;
    angle_next = ANGLE_W'(turns_res) * UNITS_PER_TURN + ANGLE_W'(s1_part);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      channel_out <= s1_channel;
      angle       <= angle_next;
      turns       <= turns_res;
    end
  end

endmodule

### rtl/mta_checker.sv
`include "assert_macros.svh"

module mta_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_stall,
  input mta_pkg::channel_t channel,
  input logic              result_valid,
  input logic              result_stall,
  input mta_pkg::channel_t channel_out,
  input mta_pkg::angle_t   angle,
  input mta_pkg::turns_t   turns
);
  import mta_pkg::*;

  // The result register is empty right after reset.
  `MTA_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !result_valid)

  // A stalled result keeps its contents.
  `MTA_ASSERT(a_result_hold, result_valid && result_stall |=> result_valid && $stable(angle) && $stable(turns) && $stable(channel_out))

  // Channels below the multi-turn range never report turns.
  `MTA_ASSERT(a_single_no_turns, result_valid && (channel_out < FIRST_MULTI_CHANNEL) |-> turns == '0)

  // With the receiver free, a sample passes the middle stage and reaches the result register.
  `MTA_ASSERT(a_latency, (sample_valid && !sample_stall) ##1 !result_stall |=> result_valid && (channel_out == $past(channel, 2)))

endmodule

bind multi_turn_angle_tracker mta_checker u_mta_checker (.*);
